// File: hw/rtl/rma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPM moving average package
// Field widths, reset values and derived constants shared by the core.
// ----------------------------------------------------------------------------
package rma_pkg;

    // Widths of the transfer fields.
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 8;

    // Running sum width, wide enough for 64 samples of full scale.
    localparam int SUM_W = 22;

    // The divider retires one quotient bit per cycle over the whole sum.
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Reset value of the error count ceiling.
    localparam logic [ERR_W-1:0] ERR_MAX_RST = 8'd5;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [ERR_W-1:0]    t_err;

endpackage
`default_nettype wire

// File: hw/rtl/rma_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPM moving average sample RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/rpm_moving_average_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPM moving average core
// Boxcar average of blower speed readings with warm-up and a saturating
// count of consecutive failed reads.
// ----------------------------------------------------------------------------
// A good reading goes from its input transfer to a ready result in steps:
// the reading is taken and the oldest sample fetched from the sample RAM,
// the running sum is updated, the bit-serial divider runs (one quotient bit
// per cycle over the 22-bit sum) and the output register is loaded once it
// is free. A failed read only bumps the error count, so it skips the sum and
// the divider. The next input transfer is taken as soon as the result sits
// in the output register, even while the consumer still stalls it. Until the
// window holds WINDOW good readings, the average is taken over the readings
// seen so far. The user must write the error count ceiling through i_cfg_we
// and i_cfg_data while the core is idle (not enforced by the core); it resets to 5.
// ----------------------------------------------------------------------------
module rpm_moving_average_core #(
    parameter int WINDOW = 50
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_cfg_we,
    input  wire logic [rma_pkg::ERR_W-1:0] i_cfg_data,

    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [rma_pkg::SAMPLE_W-1:0] i_rpm_sample,
    input  wire logic                     i_read_ok,

    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [rma_pkg::SAMPLE_W-1:0]  o_avg_rpm,
    output logic                          o_avg_changed,
    output logic [rma_pkg::ERR_W-1:0]     o_error_count
);

    import rma_pkg::*;

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    t_err                  r_err_max;
    t_err                  r_fail;
    t_sample               r_sample;
    logic                  r_ok;
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [CNT_W-1:0]      r_fill;
    t_sum                  r_sum;
    t_sample               r_last;

    // Divider: r_quo shifts the dividend out at the top while quotient bits
    // enter at the bottom; r_rem holds the partial remainder.
    t_sum                  r_quo;
    logic [CNT_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0]  r_step;

    t_sample               r_avg;
    logic                  r_changed;
    t_err                  r_err_out;
    logic                  r_out_valid;

    logic                  in_xfer;
    logic                  out_free;
    logic                  full;
    t_sample               ram_rdata;
    t_sum                  n_sum;
    logic [CNT_W-1:0]      n_fill;
    logic [CNT_W:0]        rem_sh;
    logic                  q_bit;
    t_sample               quo_avg;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_fill == CNT_W'(WINDOW));
    assign quo_avg  = r_quo[SAMPLE_W-1:0];

    // The sample RAM is read at the write pointer every cycle, so the oldest
    // sample is ready in the cycle after the input transfer.
    rma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_SUM),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_sample),
        .i_raddr (r_wr_ptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // Once the window is full the oldest sample leaves the sum.
        if (full) begin
            n_sum  = r_sum - SUM_W'(ram_rdata) + SUM_W'(r_sample);
            n_fill = r_fill;
        end else begin
            n_sum  = r_sum + SUM_W'(r_sample);
            n_fill = r_fill + CNT_W'(1);
        end
    end

    // One restoring division step.
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_fill});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err_max   <= ERR_MAX_RST;
            r_fail      <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_err_max <= i_cfg_data;
            end

            // A new result may be loaded in the same cycle the old one leaves.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sample <= i_rpm_sample;
                        r_ok     <= i_read_ok;
                        if (i_read_ok) begin
                            r_fail  <= '0;
                            r_state <= S_SUM;
                        end else begin
                            if (r_fail < r_err_max) begin
                                r_fail <= r_fail + ERR_W'(1);
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SUM: begin
                    r_sum    <= n_sum;
                    r_fill   <= n_fill;
                    r_wr_ptr <= (r_wr_ptr == PTR_W'(WINDOW - 1)) ? '0
                                                                 : r_wr_ptr + PTR_W'(1);
                    r_quo    <= n_sum;
                    r_rem    <= '0;
                    r_step   <= DIV_CNT_W'(SUM_W - 1);
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= q_bit ? CNT_W'(rem_sh - {1'b0, r_fill}) : rem_sh[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], q_bit};
                    r_step <= r_step - DIV_CNT_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        if (r_ok) begin
                            r_avg     <= quo_avg;
                            r_changed <= (quo_avg != r_last);
                            r_last    <= quo_avg;
                        end else begin
                            r_avg     <= r_last;
                            r_changed <= 1'b0;
                        end
                        r_err_out   <= r_fail;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_avg_rpm     = r_avg;
    assign o_avg_changed = r_changed;
    assign o_error_count = r_err_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr < PTR_W'(WINDOW))
        else $error("write pointer beyond window");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_fill != '0))
        else $error("division by an empty window");

    a_changed_clears_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_avg_changed) |-> (o_error_count == '0))
        else $error("average changed on a failed read");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("second transfer taken while busy");
`endif

endmodule
`default_nettype wire

// File: bench/rpm_avg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM moving average result checker
// Watches the register port and both transfer channels, predicts the result
// of every accepted reading and compares it field by field with the core.
// ----------------------------------------------------------------------------
module rpm_avg_checker
    import rma_pkg::*;
#(
    parameter int WINDOW = 50
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  t_err    i_cfg_data,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_sample i_rpm_sample,
    input  logic    i_read_ok,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_sample i_avg_rpm,
    input  logic    i_avg_changed,
    input  t_err    i_error_count,
    output int      o_mismatches,
    output int      o_pending,
    output int      o_checked,
    output int      o_avg_changes
);

    // The core holds at most one result in flight and one in its output
    // register, so a small ring of expectations is plenty.
    localparam int EXP_DEPTH = 8;

    typedef struct packed {
        t_sample avg_rpm;
        logic    avg_changed;
        t_err    error_count;
    } t_avg_result;

    t_avg_result exp_ring [EXP_DEPTH];
    int          exp_head;
    int          exp_tail;
    int          exp_count;

    // Private copy of the core state and of its one register.
    t_sample window_ring [WINDOW];
    int      ring_ptr;
    int      ring_fill;
    t_sum    ring_sum;
    t_sample prev_avg;
    t_err    read_failures;
    t_err    err_ceiling;

    task automatic predict_average(input t_sample sample, input logic ok,
                                   output t_avg_result res);
        t_sum    quotient;
        t_sample new_avg;
        res.avg_changed = 1'b0;
        if (ok) begin
            read_failures = '0;
            // Once the ring is full, the slot about to be written holds the oldest sample.
            if (ring_fill >= WINDOW) begin
                ring_sum = ring_sum - t_sum'(window_ring[ring_ptr]);
            end else begin
                ring_fill++;
            end
            window_ring[ring_ptr] = sample;
            ring_sum = ring_sum + t_sum'(sample);
            ring_ptr = (ring_ptr + 1 >= WINDOW) ? 0 : ring_ptr + 1;
            quotient = ring_sum / t_sum'(ring_fill);
            new_avg  = quotient[SAMPLE_W-1:0];
            if (new_avg != prev_avg) begin
                prev_avg        = new_avg;
                res.avg_changed = 1'b1;
            end
        end else if (read_failures < err_ceiling) begin
            read_failures = read_failures + t_err'(1);
        end
        res.avg_rpm     = prev_avg;
        res.error_count = read_failures;
    endtask

    task automatic report_field(input string field, input logic [31:0] expected,
                                input logic [31:0] actual);
        if (actual !== expected) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_avg_result want;
        t_avg_result seen;
        if (!i_rst_n) begin
            ring_ptr      = 0;
            ring_fill     = 0;
            ring_sum      = '0;
            prev_avg      = '0;
            read_failures = '0;
            err_ceiling   = ERR_MAX_RST;
            exp_head      = 0;
            exp_tail      = 0;
            exp_count     = 0;
        end else begin
            if (i_cfg_we) begin
                err_ceiling = i_cfg_data;
            end
            // A result can never belong to a reading taken at the same edge,
            // so the output side is handled first.
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_avg_rpm, i_avg_changed, i_error_count};
                if (exp_count == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual avg_rpm %0d",
                             $time, seen.avg_rpm);
                    o_mismatches++;
                end else begin
                    want      = exp_ring[exp_head];
                    exp_head  = (exp_head + 1) % EXP_DEPTH;
                    exp_count = exp_count - 1;
                    report_field("avg_rpm", 32'(want.avg_rpm), 32'(seen.avg_rpm));
                    report_field("avg_changed", 32'(want.avg_changed),
                                 32'(seen.avg_changed));
                    report_field("error_count", 32'(want.error_count),
                                 32'(seen.error_count));
                    o_checked++;
                    if (want.avg_changed) begin
                        o_avg_changes++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_average(i_rpm_sample, i_read_ok, want);
                if (exp_count == EXP_DEPTH) begin
                    $display("%0t ns: too many results outstanding, expected at most %0d, actual %0d",
                             $time, EXP_DEPTH, exp_count + 1);
                    o_mismatches++;
                end else begin
                    exp_ring[exp_tail] = want;
                    exp_tail  = (exp_tail + 1) % EXP_DEPTH;
                    exp_count = exp_count + 1;
                end
            end
        end
        o_pending = exp_count;
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPM moving average core testbench
// Drives speed readings and error ceiling settings into the core, with
// bursty input traffic and a patterned output stall, and leaves prediction
// and comparison to the checker instantiated beside the core.
// ----------------------------------------------------------------------------
module tb;
    import rma_pkg::*;

    localparam int WINDOW       = 50;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    // Far beyond the slowest legal run.
    localparam int RUN_LIMIT_NS = 8_000_000;
    // This margin after the last result catches late stray results.
    localparam int SETTLE_CYCLES = 40;

    // Kinds of random reading segments.
    typedef enum int {
        SEG_RANDOM,
        SEG_HELD,
        SEG_FAILS,
        SEG_SMALL
    } t_seg_kind;

    // Styles of the output stall pattern.
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_LONG,
        STALL_THIRD
    } t_stall_style;

    // Every input starts at a known value before the first edge.
    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    cfg_we     = 1'b0;
    t_err    cfg_data   = '0;
    logic    in_valid   = 1'b0;
    t_sample rpm_sample = '0;
    logic    read_ok    = 1'b0;
    logic    out_stall  = 1'b0;

    logic    in_stall;
    logic    out_valid;
    t_sample avg_rpm;
    logic    avg_changed;
    t_err    error_count;

    int mismatches;
    int pending;
    int checked;
    int avg_changes;

    // Stimulus bookkeeping.
    int   readings_sent = 0;
    int   failed_sent   = 0;
    int   burst_left    = 0;
    bit   gaps_on       = 1'b1;
    bit   stalls_on     = 1'b1;
    t_err random_ceiling;

    always #CLK_HALF clk = ~clk;

    rpm_moving_average_core #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_rpm_sample (rpm_sample),
        .i_read_ok    (read_ok),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_avg_rpm    (avg_rpm),
        .o_avg_changed(avg_changed),
        .o_error_count(error_count)
    );

    rpm_avg_checker #(
        .WINDOW(WINDOW)
    ) u_avg_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_rpm_sample (rpm_sample),
        .i_read_ok    (read_ok),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_avg_rpm    (avg_rpm),
        .i_avg_changed(avg_changed),
        .i_error_count(error_count),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_avg_changes(avg_changes)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        #RUN_LIMIT_NS;
        $display("*** FAILED ***");
        $finish;
    end

    // The consumer stalls on a pattern that changes style when its counter
    // runs out: no stall, a coin flip per cycle, long stall stretches of
    // random length, or a stall when the counter is a multiple of three. The
    // counters are private to this process, so blocking updates are safe.
    t_stall_style stall_style = STALL_NONE;
    int           stall_style_left = 0;
    int           stall_hold = 0;
    logic         stall_level = 1'b0;

    always @(negedge clk) begin
        if (!rst_n || !stalls_on) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_style_left == 0) begin
                stall_style      = t_stall_style'($urandom_range(0, 3));
                stall_style_left = $urandom_range(50, 400);
                stall_hold       = 0;
            end
            stall_style_left--;
            case (stall_style)
                STALL_NONE: begin
                    out_stall <= 1'b0;
                end
                STALL_COIN: begin
                    out_stall <= ($urandom_range(0, 1) == 1);
                end
                STALL_LONG: begin
                    if (stall_hold == 0) begin
                        stall_level = ~stall_level;
                        stall_hold  = stall_level ? $urandom_range(1, 30)
                                                  : $urandom_range(1, 8);
                    end
                    stall_hold--;
                    out_stall <= stall_level;
                end
                default: begin
                    out_stall <= (stall_style_left % 3 == 0);
                end
            endcase
        end
    end

    // Offers one reading and returns at the falling edge after its transfer.
    // The producer works in bursts of 1 to 12 transfers separated by idle
    // gaps of random length, so gaps end at varying points of the core's
    // computation. Valid stays high between back-to-back transfers and the
    // payload holds while the core stalls it.
    task automatic send_reading(input t_sample sample, input logic ok);
        if (gaps_on && burst_left == 0) begin
            in_valid   <= 1'b0;
            rpm_sample <= t_sample'($urandom);
            read_ok    <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 40)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        rpm_sample <= sample;
        read_ok    <= ok;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
        readings_sent++;
        if (!ok) begin
            failed_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Every reading produces a result, so the core is idle once the checker
    // holds no outstanding expectation.
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_error_ceiling(input t_err ceiling);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= ceiling;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Random readings in segments: plain random values, runs of one held
    // value (so the average settles and stops changing), runs of failed
    // reads, and small values where truncation of the average shows most.
    task automatic random_readings(input int count);
        int        left;
        int        seg_len;
        t_seg_kind kind;
        t_sample   held;
        left = count;
        while (left > 0) begin
            kind = t_seg_kind'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0:       held = '0;
                1:       held = '1;
                default: held = t_sample'($urandom);
            endcase
            seg_len = (kind == SEG_HELD) ? $urandom_range(1, 60) :
                      (kind == SEG_FAILS) ? $urandom_range(1, 8) : $urandom_range(1, 20);
            if (seg_len > left) begin
                seg_len = left;
            end
            for (int i = 0; i < seg_len; i++) begin
                case (kind)
                    SEG_RANDOM: send_reading(t_sample'($urandom), 1'b1);
                    SEG_HELD:   send_reading(held, 1'b1);
                    SEG_FAILS:  send_reading(t_sample'($urandom), 1'b0);
                    default:    send_reading(t_sample'($urandom_range(0, 15)), 1'b1);
                endcase
            end
            left -= seg_len;
        end
    endtask

    initial begin
        int fail_run;

        // Synchronous reset, held for a fixed number of cycles.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset ceiling of 5. A first sample of zero
        // leaves the average at its reset value, so no change is flagged.
        send_reading(16'h0000, 1'b1);
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'hFFFF, 1'b1);
        // Seven failed reads push the error count into its ceiling and hold there.
        for (int i = 0; i < 7; i++) begin
            send_reading(16'hFFFF, 1'b0);
        end
        // A good read clears the error count.
        send_reading(16'h0000, 1'b1);
        send_reading(16'h0001, 1'b1);
        send_reading(16'hAAAA, 1'b1);
        send_reading(16'h5555, 1'b1);
        send_reading(16'h8000, 1'b0);
        send_reading(16'h0002, 1'b1);

        // With a zero ceiling, failed reads never raise the error count.
        write_error_ceiling(8'd0);
        for (int i = 0; i < 3; i++) begin
            send_reading(16'h0000, 1'b0);
        end
        send_reading(16'h7FFF, 1'b1);
        random_readings(20);

        // Ceiling of one, with neither side idling. A run of full-scale
        // readings longer than the window drives the running sum to its
        // largest value and keeps the wrap of the ring busy.
        write_error_ceiling(8'd1);
        gaps_on = 1'b0;
        stalls_on <= 1'b0;
        for (int i = 0; i < WINDOW + 2; i++) begin
            send_reading(16'hFFFF, 1'b1);
        end
        random_readings(15);
        gaps_on = 1'b1;
        stalls_on <= 1'b1;

        // Full-range ceiling, then a failure run long enough to saturate it.
        write_error_ceiling(8'd255);
        random_readings(20);
        fail_run = $urandom_range(256, 260);
        for (int i = 0; i < fail_run; i++) begin
            send_reading(t_sample'($urandom), 1'b0);
        end

        // Lowering the ceiling below the current count: the count holds
        // until the next good read clears it.
        write_error_ceiling(8'd4);
        for (int i = 0; i < 3; i++) begin
            send_reading(t_sample'($urandom), 1'b0);
        end
        random_readings(20);

        // Random ceiling for the rest of the run.
        random_ceiling = t_err'($urandom_range(0, 255));
        write_error_ceiling(random_ceiling);
        random_readings(45);

        // Wait for the last result, then give any stray transfer time to show.
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d readings (%0d failed) under error ceilings 5, 0, 1, 255, 4, %0d.",
                 readings_sent, failed_sent, random_ceiling);
        $display("Checked %0d results, %0d with a new average; %0d mismatches.",
                 checked, avg_changes, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
